[rtl/dga_pkg.sv]
// Shared types and constants for the double-byte glyph address block.
package dga_pkg;

	localparam int BYTE_PIXELS = 8;

	localparam int CODE_W   = 16;
	localparam int IDX_W    = 15;
	localparam int BYTES_W  = 9;
	localparam int OFFSET_W = 24;
	localparam int INFO_W   = 32;
	localparam int HEIGHT_W = 6;
	localparam int START_W  = 16;
	localparam int CP_W     = 3;
	localparam int REG_IDX_W = 2;
	localparam int INFO_HEIGHT_LSB = 26;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CODE_PAGE    = 2'd0,
		REG_GLYPH_HEIGHT = 2'd1,
		REG_DATA_START   = 2'd2,
		REG_PROP_MODE    = 2'd3
	} reg_idx_t;

	localparam logic [CP_W-1:0] CP_932 = 3'd0;
	localparam logic [CP_W-1:0] CP_936 = 3'd1;
	localparam logic [CP_W-1:0] CP_949 = 3'd2;
	localparam logic [CP_W-1:0] CP_950 = 3'd3;

	localparam logic [IDX_W-1:0] CELLS_932 = 15'd188;
	localparam logic [IDX_W-1:0] CELLS_936 = 15'd94;
	localparam logic [IDX_W-1:0] CELLS_949 = 15'd188;
	localparam logic [IDX_W-1:0] CELLS_950 = 15'd157;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} dga_idx_t;

endpackage

[rtl/dbcs_glyph_address.sv]
// Top level: glyph address generator for double-byte bitmap fonts.
// One character code is taken on every cycle that start is high (busy stays low) and its
// result appears with done after three register stages, one result per code, in order; the
// stages are the input register, the code page index decode and the
// index-times-glyph-size multiply. The receiver has no way to stall: each result is on the
// ports for the single cycle that done is high. Write configuration only while no code is
// in flight.
module dbcs_glyph_address #(
	parameter int INDEX_ENTRY_BYTES = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [dga_pkg::CODE_W-1:0]       char_code,
	input  logic                             cfg_wr_en,
	input  logic [dga_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [dga_pkg::START_W-1:0]      cfg_wdata,
	output logic                             done,
	output logic                             found,
	output logic                             table_entry,
	output logic [dga_pkg::OFFSET_W-1:0]     byte_offset,
	output logic [dga_pkg::INFO_W-1:0]       char_info,
	output logic [dga_pkg::HEIGHT_W-1:0]     glyph_width
);
	import dga_pkg::*;

	logic [CP_W-1:0]     code_page_q;
	logic [HEIGHT_W-1:0] glyph_height_q;
	logic [START_W-1:0]  data_start_q;
	logic                prop_mode_q;
	logic [BYTES_W-1:0]  glyph_bytes_q;

	logic [HEIGHT_W-1:0] wr_height;
	logic [6:0]          wr_cols;
	logic [BYTES_W-1:0]  wr_bytes;

	logic                valid_s1;
	logic [CODE_W-1:0]   code_s1;
	dga_idx_t            idx_comb;
	logic [OFFSET_W-1:0] tbl_off_comb;

	logic                valid_s2;
	dga_idx_t            idx_s2;
	logic                tbl_hit_s2;
	logic [OFFSET_W-1:0] tbl_off_s2;

	logic [OFFSET_W-1:0] glyph_prod;
	logic [OFFSET_W-1:0] glyph_off;

	logic                done_q;
	logic                found_q;
	logic                table_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [INFO_W-1:0]   info_q;
	logic [HEIGHT_W-1:0] width_q;

	assign wr_height = cfg_wdata[HEIGHT_W-1:0];
	assign wr_cols   = 7'(({1'b0, wr_height} + 7'(BYTE_PIXELS - 1)) / 7'(BYTE_PIXELS));
	assign wr_bytes  = BYTES_W'(wr_cols) * BYTES_W'(wr_height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_page_q    <= CP_936;
			glyph_height_q <= 6'd16;
			glyph_bytes_q  <= 9'd32;
			data_start_q   <= '0;
			prop_mode_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CODE_PAGE: begin
					code_page_q <= cfg_wdata[CP_W-1:0];
				end
				REG_GLYPH_HEIGHT: begin
					glyph_height_q <= wr_height;
					glyph_bytes_q  <= wr_bytes;
				end
				REG_DATA_START: begin
					data_start_q <= cfg_wdata;
				end
				REG_PROP_MODE: begin
					prop_mode_q <= cfg_wdata[0];
				end
				default: begin
					prop_mode_q <= prop_mode_q;
				end
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			code_s1 <= char_code;
		end
	end

	dga_index_map u_index_map (
		.code_page (code_page_q),
		.char_code (code_s1),
		.idx_out   (idx_comb)
	);

	assign tbl_off_comb = {8'd0, data_start_q} +
	                      {16'd0, code_s1[7:0]} * OFFSET_W'(INDEX_ENTRY_BYTES);

	// stage 2: decoded index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			idx_s2     <= idx_comb;
			tbl_hit_s2 <= (code_s1[15:8] == 8'd0);
			tbl_off_s2 <= tbl_off_comb;
		end
	end

	assign glyph_prod = {9'd0, idx_s2.idx} * {15'd0, glyph_bytes_q};
	assign glyph_off  = {8'd0, data_start_q} + glyph_prod;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			if (prop_mode_q) begin
				found_q  <= tbl_hit_s2;
				table_q  <= tbl_hit_s2;
				offset_q <= tbl_hit_s2 ? tbl_off_s2 : '0;
				info_q   <= '0;
				width_q  <= '0;
			end else begin
				found_q  <= idx_s2.hit;
				table_q  <= 1'b0;
				offset_q <= idx_s2.hit ? glyph_off : '0;
				info_q   <= idx_s2.hit ? {glyph_height_q, 2'b00, glyph_off} : '0;
				width_q  <= idx_s2.hit ? glyph_height_q : '0;
			end
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign table_entry = table_q;
	assign byte_offset = offset_q;
	assign char_info   = info_q;
	assign glyph_width = width_q;

endmodule

[rtl/dga_index_map.sv]
// Row/cell to glyph index decoder for the supported double-byte code pages.
module dga_index_map (
	input  logic [dga_pkg::CP_W-1:0]   code_page,
	input  logic [dga_pkg::CODE_W-1:0] char_code,
	output dga_pkg::dga_idx_t          idx_out
);
	import dga_pkg::*;

	logic [7:0]       r;
	logic [7:0]       c;
	logic [IDX_W-1:0] row;
	logic [IDX_W-1:0] col;

	assign r = char_code[15:8];
	assign c = char_code[7:0];

	always_comb begin
		idx_out = '0;
		row = '0;
		col = '0;
		unique case (code_page)
			CP_932: begin
				if (r >= 8'h81 && r <= 8'h9F) begin
					row = 15'(r - 8'h81);
				end else begin
					row = 15'(r - 8'hE0) + 15'd31;
				end
				if (c >= 8'h40 && c <= 8'h7E) begin
					col = 15'(c - 8'h40);
				end else begin
					col = 15'(c - 8'h80) + 15'd63;
				end
				idx_out.hit = ((r >= 8'h81 && r <= 8'h9F) || (r >= 8'hE0 && r <= 8'hFC)) &&
				              ((c >= 8'h40 && c <= 8'h7E) || (c >= 8'h80 && c <= 8'hFC));
				idx_out.idx = row * CELLS_932 + col;
			end
			CP_936: begin
				row = 15'(r - 8'hA1);
				col = 15'(c - 8'hA1);
				idx_out.hit = (r >= 8'hA1 && r <= 8'hFE) && (c >= 8'hA1 && c <= 8'hFE);
				idx_out.idx = row * CELLS_936 + col;
			end
			CP_949: begin
				row = 15'(r - 8'h81);
				if (c >= 8'h41 && c <= 8'h7E) begin
					col = 15'(c - 8'h41);
				end else begin
					col = 15'(c - 8'h81) + 15'd62;
				end
				idx_out.hit = (r >= 8'h81) &&
				              ((c >= 8'h41 && c <= 8'h7E) || (c >= 8'h81 && c <= 8'hFE));
				idx_out.idx = row * CELLS_949 + col;
			end
			CP_950: begin
				row = 15'(r - 8'hA1);
				if (c >= 8'h40 && c <= 8'h7E) begin
					col = 15'(c - 8'h40);
				end else begin
					col = 15'(c - 8'hA1) + 15'd63;
				end
				idx_out.hit = (r >= 8'hA1 && r <= 8'hFE) &&
				              ((c >= 8'h40 && c <= 8'h7E) || (c >= 8'hA1 && c <= 8'hFE));
				idx_out.idx = row * CELLS_950 + col;
			end
			default: begin
				idx_out = '0;
			end
		endcase
	end

endmodule

[rtl/dga_checker.sv]
// Port-level assertions for the glyph address block, bound to the top level.
module dga_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         found,
	input logic                         table_entry,
	input logic [dga_pkg::OFFSET_W-1:0] byte_offset,
	input logic [dga_pkg::INFO_W-1:0]   char_info,
	input logic [dga_pkg::HEIGHT_W-1:0] glyph_width
);
	import dga_pkg::*;

	a_transfer_yields_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted code produced no result");

	a_result_has_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without an accepted code");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (!table_entry && byte_offset == '0 && char_info == '0 &&
		                      glyph_width == '0))
		else $error("miss result carries nonzero fields");

	a_table_hit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_entry) |-> (found && char_info == '0 && glyph_width == '0))
		else $error("index table result has glyph fields");

	a_glyph_info_packing: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found && !table_entry) |->
			(char_info[OFFSET_W-1:0] == byte_offset && char_info[25:24] == 2'b00 &&
			 char_info[INFO_W-1:INFO_HEIGHT_LSB] == glyph_width))
		else $error("glyph info word does not match offset and width");

endmodule

bind dbcs_glyph_address dga_checker u_dga_checker (.*);
